FILE: design/m3inv_pkg.sv
package m3inv_pkg;

    localparam int EntW = 16;
    localparam int CofW = 33;
    localparam int DetW = 49;
    localparam int NumW = 57;
    localparam int MagN = 56;
    localparam int MagD = 48;
    localparam int QuoW = 32;
    localparam int NEnt = 9;
    localparam int IdxW = 4;
    localparam logic [IdxW-1:0] LastIdx = 4'd8;

    typedef struct packed {
        logic signed [EntW-1:0] a00;
        logic signed [EntW-1:0] a01;
        logic signed [EntW-1:0] a02;
        logic signed [EntW-1:0] a10;
        logic signed [EntW-1:0] a11;
        logic signed [EntW-1:0] a12;
        logic signed [EntW-1:0] a20;
        logic signed [EntW-1:0] a21;
        logic signed [EntW-1:0] a22;
    } in_t;

    typedef struct packed {
        logic signed [QuoW-1:0] inv00;
        logic signed [QuoW-1:0] inv01;
        logic signed [QuoW-1:0] inv02;
        logic signed [QuoW-1:0] inv10;
        logic signed [QuoW-1:0] inv11;
        logic signed [QuoW-1:0] inv12;
        logic signed [QuoW-1:0] inv20;
        logic signed [QuoW-1:0] inv21;
        logic signed [QuoW-1:0] inv22;
        logic                   singular;
    } out_t;

    typedef struct packed {
        logic [NEnt-1:0][CofW-1:0] cof;
        logic [DetW-1:0]           det;
        logic [NEnt-1:0][EntW-1:0] m;
        logic                      sing;
    } q_entry_t;

    typedef struct packed {
        logic [IdxW-1:0] idx;
        logic            sing;
    } tok_t;

endpackage

FILE: design/m3inv_front.sv
module m3inv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  m3inv_pkg::in_t      in_data,
    output logic                push,
    input  logic                push_ready,
    output m3inv_pkg::q_entry_t entry
);

    function automatic logic [m3inv_pkg::CofW-1:0] cof2(
        input logic signed [m3inv_pkg::EntW-1:0] a,
        input logic signed [m3inv_pkg::EntW-1:0] b,
        input logic signed [m3inv_pkg::EntW-1:0] c,
        input logic signed [m3inv_pkg::EntW-1:0] d
    );
        logic signed [2*m3inv_pkg::EntW-1:0] p;
        logic signed [2*m3inv_pkg::EntW-1:0] q;
        p = a * b;
        q = c * d;
        return m3inv_pkg::CofW'(p) - m3inv_pkg::CofW'(q);
    endfunction

    function automatic logic signed [m3inv_pkg::DetW-1:0] term(
        input logic signed [m3inv_pkg::EntW-1:0] a,
        input logic [m3inv_pkg::CofW-1:0]        c
    );
        return m3inv_pkg::DetW'(a) * m3inv_pkg::DetW'($signed(c));
    endfunction

    logic                                    s1_valid_reg;
    logic                                    s2_valid_reg;
    m3inv_pkg::in_t                          s1_m_reg;
    logic [m3inv_pkg::NEnt-1:0][m3inv_pkg::CofW-1:0] s1_cof_reg;
    logic [m3inv_pkg::NEnt-1:0][m3inv_pkg::CofW-1:0] s1_cof_next;
    m3inv_pkg::q_entry_t                     s2_reg;
    m3inv_pkg::q_entry_t                     s2_next;
    logic                                    s1_load;
    logic                                    s2_load;
    logic signed [m3inv_pkg::DetW-1:0]       det;

    assign s2_load  = !s2_valid_reg || push_ready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;
    assign push     = s2_valid_reg;
    assign entry    = s2_reg;

    always_comb
    begin
        s1_cof_next[0] = cof2(in_data.a11, in_data.a22, in_data.a12, in_data.a21);
        s1_cof_next[1] = cof2(in_data.a12, in_data.a20, in_data.a10, in_data.a22);
        s1_cof_next[2] = cof2(in_data.a10, in_data.a21, in_data.a11, in_data.a20);
        s1_cof_next[3] = cof2(in_data.a02, in_data.a21, in_data.a01, in_data.a22);
        s1_cof_next[4] = cof2(in_data.a00, in_data.a22, in_data.a02, in_data.a20);
        s1_cof_next[5] = cof2(in_data.a01, in_data.a20, in_data.a00, in_data.a21);
        s1_cof_next[6] = cof2(in_data.a01, in_data.a12, in_data.a02, in_data.a11);
        s1_cof_next[7] = cof2(in_data.a02, in_data.a10, in_data.a00, in_data.a12);
        s1_cof_next[8] = cof2(in_data.a00, in_data.a11, in_data.a01, in_data.a10);
    end

    always_comb
    begin
        det = term(s1_m_reg.a00, s1_cof_reg[0]) + term(s1_m_reg.a01, s1_cof_reg[1])
            + term(s1_m_reg.a02, s1_cof_reg[2]);
        s2_next.cof  = s1_cof_reg;
        s2_next.det  = det;
        s2_next.sing = (det == '0);
        s2_next.m[0] = s1_m_reg.a00;
        s2_next.m[1] = s1_m_reg.a01;
        s2_next.m[2] = s1_m_reg.a02;
        s2_next.m[3] = s1_m_reg.a10;
        s2_next.m[4] = s1_m_reg.a11;
        s2_next.m[5] = s1_m_reg.a12;
        s2_next.m[6] = s1_m_reg.a20;
        s2_next.m[7] = s1_m_reg.a21;
        s2_next.m[8] = s1_m_reg.a22;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_m_reg   <= in_data;
            s1_cof_reg <= s1_cof_next;
        end
        if (s2_load && s1_valid_reg)
            s2_reg <= s2_next;
    end

endmodule

FILE: design/m3inv_queue.sv
module m3inv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                push_ready,
    input  m3inv_pkg::q_entry_t push_data,
    output logic                head_valid,
    input  logic                pop,
    output m3inv_pkg::q_entry_t head
);

    m3inv_pkg::q_entry_t mem_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: design/m3inv_div.sv
module m3inv_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic signed [m3inv_pkg::NumW-1:0]  num,
    input  logic signed [m3inv_pkg::DetW-1:0]  den,
    input  m3inv_pkg::tok_t                    in_tok,
    output logic                               out_valid,
    output m3inv_pkg::tok_t                    out_tok,
    output logic signed [m3inv_pkg::QuoW-1:0]  quot
);

    localparam int NSt = m3inv_pkg::QuoW + 1;
    localparam int PadW = m3inv_pkg::MagN - m3inv_pkg::MagD;
    localparam int HiW = m3inv_pkg::MagN - m3inv_pkg::QuoW;

    logic                              valid_reg [NSt];
    logic [m3inv_pkg::MagN-1:0]        rem_reg   [NSt];
    logic [m3inv_pkg::MagD-1:0]        den_reg   [NSt];
    logic [m3inv_pkg::QuoW-1:0]        quo_reg   [NSt];
    logic                              neg_reg   [NSt];
    logic                              ovf_reg   [NSt];
    m3inv_pkg::tok_t                   tok_reg   [NSt];

    logic [m3inv_pkg::NumW-1:0]        nabs;
    logic [m3inv_pkg::DetW-1:0]        dabs;
    logic [m3inv_pkg::QuoW-1:0]        qf;

    always_comb
    begin
        nabs = num[m3inv_pkg::NumW-1] ? m3inv_pkg::NumW'(-num) : m3inv_pkg::NumW'(num);
        dabs = den[m3inv_pkg::DetW-1] ? m3inv_pkg::DetW'(-den) : m3inv_pkg::DetW'(den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (adv)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= nabs[m3inv_pkg::MagN-1:0];
            den_reg[0] <= dabs[m3inv_pkg::MagD-1:0];
            quo_reg[0] <= '0;
            neg_reg[0] <= num[m3inv_pkg::NumW-1] ^ den[m3inv_pkg::DetW-1];
            ovf_reg[0] <= {{PadW{1'b0}}, {(m3inv_pkg::MagD-HiW){1'b0}},
                           nabs[m3inv_pkg::MagN-1:m3inv_pkg::QuoW]}
                          >= {{PadW{1'b0}}, dabs[m3inv_pkg::MagD-1:0]};
            tok_reg[0] <= in_tok;
        end
    end

    for (genvar s = 1; s < NSt; s++)
    begin : g_bit
        localparam int B = m3inv_pkg::QuoW - s;
        logic [m3inv_pkg::MagN-1:0] dsh;
        logic                       ge;
        logic [m3inv_pkg::QuoW-1:0] qn;

        always_comb
        begin
            dsh = {{PadW{1'b0}}, den_reg[s-1]} << B;
            ge  = (rem_reg[s-1] >> B) >= {{PadW{1'b0}}, den_reg[s-1]};
            qn  = quo_reg[s-1];
            qn[B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (adv)
                valid_reg[s] <= valid_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= ge ? rem_reg[s-1] - dsh : rem_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                quo_reg[s] <= qn;
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                tok_reg[s] <= tok_reg[s-1];
            end
        end
    end

    assign qf        = quo_reg[NSt-1];
    assign out_valid = valid_reg[NSt-1];
    assign out_tok   = tok_reg[NSt-1];

    always_comb
    begin
        if (neg_reg[NSt-1])
        begin
            if (ovf_reg[NSt-1] || (qf > {1'b1, {(m3inv_pkg::QuoW-1){1'b0}}}))
                quot = {1'b1, {(m3inv_pkg::QuoW-1){1'b0}}};
            else
                quot = -$signed(qf);
        end
        else
        begin
            if (ovf_reg[NSt-1] || qf[m3inv_pkg::QuoW-1])
                quot = {1'b0, {(m3inv_pkg::QuoW-1){1'b1}}};
            else
                quot = $signed(qf);
        end
    end

endmodule

FILE: design/m3inv_back.sv
module m3inv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  m3inv_pkg::q_entry_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output m3inv_pkg::out_t     out_data
);

    function automatic logic [m3inv_pkg::IdxW-1:0] adj_idx(
        input logic [m3inv_pkg::IdxW-1:0] k
    );
        logic [m3inv_pkg::IdxW-1:0] r;
        unique case (k)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd3;
            4'd2:    r = 4'd6;
            4'd3:    r = 4'd1;
            4'd4:    r = 4'd4;
            4'd5:    r = 4'd7;
            4'd6:    r = 4'd2;
            4'd7:    r = 4'd5;
            default: r = 4'd8;
        endcase
        return r;
    endfunction

    logic [m3inv_pkg::IdxW-1:0]         idx_reg;
    logic [m3inv_pkg::IdxW-1:0]         idx_next;
    logic                               adv;
    logic                               issue;
    logic signed [m3inv_pkg::NumW-1:0]  num;
    logic signed [m3inv_pkg::DetW-1:0]  den;
    m3inv_pkg::tok_t                    tok;
    logic                               d_valid;
    m3inv_pkg::tok_t                    d_tok;
    logic signed [m3inv_pkg::QuoW-1:0]  d_quot;
    logic [m3inv_pkg::QuoW-1:0]         asm_reg [8];
    logic                               out_valid_reg;
    m3inv_pkg::out_t                    out_reg;
    logic                               fin;
    logic [m3inv_pkg::CofW-1:0]         cof_sel;
    logic [m3inv_pkg::EntW-1:0]         m_sel;

    assign fin   = d_valid && (d_tok.idx == m3inv_pkg::LastIdx);
    assign adv   = !fin || !out_valid_reg || out_ready;
    assign issue = head_valid && adv;
    assign pop   = issue && (idx_reg == m3inv_pkg::LastIdx);

    always_comb
    begin
        cof_sel  = head.cof[adj_idx(idx_reg)];
        m_sel    = head.m[idx_reg];
        tok.idx  = idx_reg;
        tok.sing = head.sing;
        if (head.sing)
        begin
            num = m3inv_pkg::NumW'($signed(m_sel)) <<< 8;
            den = m3inv_pkg::DetW'(1);
        end
        else
        begin
            num = m3inv_pkg::NumW'($signed(cof_sel)) <<< 24;
            den = $signed(head.det);
        end
        if (!issue)
            idx_next = idx_reg;
        else if (idx_reg == m3inv_pkg::LastIdx)
            idx_next = '0;
        else
            idx_next = idx_reg + 4'd1;
    end

    m3inv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (issue),
        .num      (num),
        .den      (den),
        .in_tok   (tok),
        .out_valid(d_valid),
        .out_tok  (d_tok),
        .quot     (d_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (fin && adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_valid && adv && !fin)
            asm_reg[d_tok.idx[2:0]] <= d_quot;
        if (fin && adv)
        begin
            out_reg.inv00    <= asm_reg[0];
            out_reg.inv01    <= asm_reg[1];
            out_reg.inv02    <= asm_reg[2];
            out_reg.inv10    <= asm_reg[3];
            out_reg.inv11    <= asm_reg[4];
            out_reg.inv12    <= asm_reg[5];
            out_reg.inv20    <= asm_reg[6];
            out_reg.inv21    <= asm_reg[7];
            out_reg.inv22    <= d_quot;
            out_reg.singular <= d_tok.sing;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: design/matrix3_inverse_core.sv
// 3x3 matrix inverse, adjugate method, Q8.8 in, Q16.16 out.
// Input channel in_valid/in_ready/in_data carries one matrix per item;
// output channel out_valid/out_ready/out_data carries its inverse and the
// singular flag. A zero determinant returns the input scaled to Q16.16.
// The front computes cofactors and determinant in two register stages and
// pushes into a two-entry queue; it keeps taking items while the back works.
// The back feeds the nine adjugate entries, one per cycle unless stalled,
// into a shared divider with one prep stage and one stage per quotient bit
// (33 stages), then saturates and collects them into the output register.
// Throughput is set by the single divider input; entries of the next matrix
// enter the divider while earlier ones are still in flight.
// When out_ready is low the finished item is held in the output register and
// the divider freezes once the next item's last entry reaches its end;
// the queue then fills and in_ready drops.
// Reset clears all valid flags and sequencer state; no item survives reset.
module matrix3_inverse_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  m3inv_pkg::in_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output m3inv_pkg::out_t  out_data
);

    logic                push;
    logic                push_ready;
    m3inv_pkg::q_entry_t entry;
    logic                head_valid;
    logic                pop;
    m3inv_pkg::q_entry_t head;

    m3inv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_ready(push_ready),
        .entry     (entry)
    );

    m3inv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ready(push_ready),
        .push_data (entry),
        .head_valid(head_valid),
        .pop       (pop),
        .head      (head)
    );

    m3inv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: sim/tb_matrix3_inverse_core.sv
`timescale 1ns / 1ps

module tb_matrix3_inverse_core;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    m3inv_pkg::in_t  in_data;
    logic            out_valid;
    logic            out_ready;
    m3inv_pkg::out_t out_data;

    m3inv_pkg::out_t inverse_q[$];
    int              n_err;

    matrix3_inverse_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic m3inv_pkg::out_t invert3(input m3inv_pkg::in_t a);
        longint          m[9];
        longint          cf[9];
        longint          det;
        m3inv_pkg::out_t r;
        m[0] = a.a00; m[1] = a.a01; m[2] = a.a02;
        m[3] = a.a10; m[4] = a.a11; m[5] = a.a12;
        m[6] = a.a20; m[7] = a.a21; m[8] = a.a22;
        cf[0] = m[4] * m[8] - m[5] * m[7];
        cf[1] = m[5] * m[6] - m[3] * m[8];
        cf[2] = m[3] * m[7] - m[4] * m[6];
        cf[3] = m[2] * m[7] - m[1] * m[8];
        cf[4] = m[0] * m[8] - m[2] * m[6];
        cf[5] = m[1] * m[6] - m[0] * m[7];
        cf[6] = m[1] * m[5] - m[2] * m[4];
        cf[7] = m[2] * m[3] - m[0] * m[5];
        cf[8] = m[0] * m[4] - m[1] * m[3];
        det = m[0] * cf[0] + m[1] * cf[1] + m[2] * cf[2];
        if (det == 0)
        begin
            r.inv00 = clamp32(m[0] * 256); r.inv01 = clamp32(m[1] * 256);
            r.inv02 = clamp32(m[2] * 256); r.inv10 = clamp32(m[3] * 256);
            r.inv11 = clamp32(m[4] * 256); r.inv12 = clamp32(m[5] * 256);
            r.inv20 = clamp32(m[6] * 256); r.inv21 = clamp32(m[7] * 256);
            r.inv22 = clamp32(m[8] * 256);
            r.singular = 1'b1;
        end
        else
        begin
            // adjugate: transpose of the cofactors
            r.inv00 = clamp32((cf[0] <<< 24) / det);
            r.inv01 = clamp32((cf[3] <<< 24) / det);
            r.inv02 = clamp32((cf[6] <<< 24) / det);
            r.inv10 = clamp32((cf[1] <<< 24) / det);
            r.inv11 = clamp32((cf[4] <<< 24) / det);
            r.inv12 = clamp32((cf[7] <<< 24) / det);
            r.inv20 = clamp32((cf[2] <<< 24) / det);
            r.inv21 = clamp32((cf[5] <<< 24) / det);
            r.inv22 = clamp32((cf[8] <<< 24) / det);
            r.singular = 1'b0;
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_matrix(input m3inv_pkg::in_t a);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        inverse_q.push_back(invert3(a));
        @(negedge clk);
    endtask

    function automatic logic [15:0] rnd_ent();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 16'h8000;
        if (p == 1)
            return 16'h7fff;
        if (p < 5)
            return 16'($signed($urandom_range(0, 2048)) - 1024);
        return 16'($urandom);
    endfunction

    function automatic m3inv_pkg::in_t rnd_matrix();
        m3inv_pkg::in_t a;
        a = {rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent(),
             rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent()};
        return a;
    endfunction

    task automatic test_identity_and_scalars();
        send_matrix({16'sh0100, 16'sh0, 16'sh0, 16'sh0, 16'sh0100, 16'sh0,
                     16'sh0, 16'sh0, 16'sh0100});
        send_matrix({16'sh0200, 16'sh0, 16'sh0, 16'sh0, -16'sh0080, 16'sh0,
                     16'sh0, 16'sh0, 16'sh0400});
        // tiny diagonal gives a large inverse that still fits the Q16.16 range
        send_matrix({16'sh0001, 16'sh0, 16'sh0, 16'sh0, 16'sh0001, 16'sh0,
                     16'sh0, 16'sh0, 16'sh0001});
        send_matrix({-16'sh0001, 16'sh0, 16'sh0, 16'sh0, 16'sh0001, 16'sh0,
                     16'sh0, 16'sh0, 16'sh0001});
        send_matrix({16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 16'sh7fff, 16'sh0,
                     16'sh0, 16'sh0, 16'sh7fff});
        send_matrix({16'sh8000, 16'sh0, 16'sh0, 16'sh0, 16'sh8000, 16'sh0,
                     16'sh0, 16'sh0, 16'sh8000});
        send_matrix({16'sh0, 16'sh0100, 16'sh0, 16'sh0, 16'sh0, 16'sh0100,
                     16'sh0100, 16'sh0, 16'sh0});
    endtask

    task automatic test_singular();
        send_matrix('0);
        send_matrix({9{16'sh7fff}});
        send_matrix({9{16'sh8000}});
        send_matrix({16'sh8000, 16'sh7fff, 16'sh1234, 16'sh8000, 16'sh7fff,
                     16'sh1234, -16'sh0001, 16'sh0001, 16'sh0});
        send_matrix({16'sh0100, 16'sh0200, 16'sh0300, 16'sh0200, 16'sh0400,
                     16'sh0600, 16'sh0011, 16'sh7fff, 16'sh8000});
    endtask

    task automatic test_extremes();
        send_matrix({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff});
        send_matrix({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                     16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000});
        send_matrix({16'sh0001, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0001,
                     16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0002});
        send_matrix({16'shffff, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
                     16'shffff, 16'shaaaa, 16'shffff, 16'sh5556});
    endtask

    task automatic test_random();
        m3inv_pkg::in_t a;
        for (int i = 0; i < 1130; i++)
        begin
            a = rnd_matrix();
            // make some rows dependent so singular items keep showing up
            if ($urandom_range(0, 9) == 0)
                {a.a20, a.a21, a.a22} = {a.a00, a.a01, a.a02};
            send_matrix(a);
        end
    endtask

    initial
    begin
        int p;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            p = $urandom_range(0, 99);
            if (p < 60)
                out_ready <= 1'b1;
            else if (p < 95)
                out_ready <= 1'b0;
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 80)) @(negedge clk);
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 200)) @(negedge clk);
            end
        end
    end

    initial
    begin
        m3inv_pkg::out_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $error("result with no matrix pending: %h", out_data);
                    n_err++;
                end
                else
                begin
                    e = inverse_q.pop_front();
                    if (out_data.inv00 !== e.inv00)
                    begin $error("inv00 exp %0d got %0d", e.inv00, out_data.inv00); n_err++; end
                    if (out_data.inv01 !== e.inv01)
                    begin $error("inv01 exp %0d got %0d", e.inv01, out_data.inv01); n_err++; end
                    if (out_data.inv02 !== e.inv02)
                    begin $error("inv02 exp %0d got %0d", e.inv02, out_data.inv02); n_err++; end
                    if (out_data.inv10 !== e.inv10)
                    begin $error("inv10 exp %0d got %0d", e.inv10, out_data.inv10); n_err++; end
                    if (out_data.inv11 !== e.inv11)
                    begin $error("inv11 exp %0d got %0d", e.inv11, out_data.inv11); n_err++; end
                    if (out_data.inv12 !== e.inv12)
                    begin $error("inv12 exp %0d got %0d", e.inv12, out_data.inv12); n_err++; end
                    if (out_data.inv20 !== e.inv20)
                    begin $error("inv20 exp %0d got %0d", e.inv20, out_data.inv20); n_err++; end
                    if (out_data.inv21 !== e.inv21)
                    begin $error("inv21 exp %0d got %0d", e.inv21, out_data.inv21); n_err++; end
                    if (out_data.inv22 !== e.inv22)
                    begin $error("inv22 exp %0d got %0d", e.inv22, out_data.inv22); n_err++; end
                    if (out_data.singular !== e.singular)
                    begin
                        $error("singular exp %0b got %0b", e.singular, out_data.singular);
                        n_err++;
                    end
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        n_err     = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_identity_and_scalars();
        test_singular();
        test_extremes();
        test_random();
        in_valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (n_err == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
design/m3inv_pkg.sv
design/m3inv_front.sv
design/m3inv_queue.sv
design/m3inv_div.sv
design/m3inv_back.sv
design/matrix3_inverse_core.sv
sim/tb_matrix3_inverse_core.sv
